// File: design/assert_macros.svh
// Assertion helpers used by glyph_column_color_expander
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is low
`define GCCE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define GCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gcce_pkg.sv
`timescale 1ns / 1ps

package gcce_pkg;

  // Field widths of the transactions
  localparam int unsigned OpW       = 1;
  localparam int unsigned CharW     = 9;
  localparam int unsigned PosW      = 12;
  localparam int unsigned ColorW    = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned KindW     = 2;
  localparam int unsigned PixAddrW  = 24;
  localparam int unsigned FontAddrW = 16;

  // Configuration port widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Shared multiply-add operand width
  localparam int unsigned MulW = 12;

  // Opcodes of an input transaction
  localparam logic [OpW-1:0] OP_BEGIN = 1'b0;
  localparam logic [OpW-1:0] OP_BYTE  = 1'b1;

  // Result kinds
  localparam logic [KindW-1:0] KIND_REQ  = 2'd0;
  localparam logic [KindW-1:0] KIND_PIX  = 2'd1;
  localparam logic [KindW-1:0] KIND_DONE = 2'd2;
  localparam logic [KindW-1:0] KIND_ERR  = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GLYPH_WIDTH    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GLYPH_HEIGHT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROW_BYTE_COUNT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SYMBOL_BYTES   = 3'd4;

  // Highest character code that is drawn
  localparam logic [CharW-1:0] MAX_CHAR = 9'd255;

  // Column word and row limits
  localparam int unsigned ColBitsW = 32;
  localparam logic [5:0]  MAX_ROWS = 6'd32;
  localparam logic [2:0]  MAX_ROW_BYTES = 3'd4;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [5:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [2:0]  row_byte_count;
    logic [7:0]  symbol_bytes;
  } gcce_cfg_t;

  localparam gcce_cfg_t CFG_RESET = '{
    screen_width:   12'd320,
    glyph_width:    6'd8,
    glyph_height:   6'd16,
    row_byte_count: 3'd2,
    symbol_bytes:   8'd16
  };

endpackage

// File: design/gcce_in_if.sv
`timescale 1ns / 1ps

interface gcce_in_if;
  logic                            valid;
  logic                            ready;
  logic [gcce_pkg::OpW-1:0]        opcode;
  logic [gcce_pkg::CharW-1:0]      char_index;
  logic [gcce_pkg::PosW-1:0]       pos_x;
  logic [gcce_pkg::PosW-1:0]       pos_y;
  logic [gcce_pkg::ColorW-1:0]     fore_color;
  logic [gcce_pkg::ColorW-1:0]     back_color;
  logic [gcce_pkg::ByteW-1:0]      glyph_byte;

  modport source (
    output valid, opcode, char_index, pos_x, pos_y, fore_color, back_color, glyph_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, char_index, pos_x, pos_y, fore_color, back_color, glyph_byte,
    output ready
  );
endinterface

// File: design/gcce_out_if.sv
`timescale 1ns / 1ps

interface gcce_out_if;
  logic                             valid;
  logic                             ready;
  logic [gcce_pkg::KindW-1:0]       result_kind;
  logic [gcce_pkg::PixAddrW-1:0]    pixel_addr;
  logic [gcce_pkg::ColorW-1:0]      pixel_color;
  logic [gcce_pkg::FontAddrW-1:0]   font_addr;
  logic                             last;

  modport source (
    output valid, result_kind, pixel_addr, pixel_color, font_addr, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, pixel_addr, pixel_color, font_addr, last,
    output ready
  );
endinterface

// File: design/gcce_cfg_if.sv
`timescale 1ns / 1ps

interface gcce_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gcce_pkg::CfgIdxW-1:0]    index;
  logic [gcce_pkg::CfgDataW-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: design/glyph_column_color_expander.sv
`timescale 1ns / 1ps
// Glyph column color expander: draws one bitmap-font character into a
// 32-bit-per-pixel frame buffer.
// Channels: item_i takes begin transactions (character, cell position,
// colors) and glyph byte transactions; result_o returns font byte
// requests, pixel writes, a done marker, or an error; cfg_i writes the
// five geometry registers and is always ready.
// Timing: one transaction is worked at a time, and item_i is ready only
// while the sequencer is idle. All address math runs through a single
// registered 12x12 multiply-add unit. A begin steps S_SYM, S_CELL,
// S_CELL_B, then S_FONT_A, S_FONT_B, S_REQ to its request, or S_DONE
// when the glyph width is zero; a byte that does not close a column
// steps S_FONT_A, S_FONT_B, S_REQ. One that closes it steps S_PIX_BASE,
// then S_PIX gives glyph_height pixel writes (at most 32), one per cycle
// unless result_o stalls, then S_COL_END leads to S_DONE or the next
// request. item_i is ready again once the final result is loaded.
// One result register sits on result_o: a stalled receiver holds the
// sequencer in its emitting state, nothing is dropped.
// Reset: registers return to 320x, 8 wide, 16 high, 2 row bytes,
// 16 bytes per symbol; no character is in progress.
`include "assert_macros.svh"

module glyph_column_color_expander #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcce_in_if.sink     item_i,
  gcce_out_if.source  result_o,
  gcce_cfg_if.sink    cfg_i
);
  import gcce_pkg::*;

  localparam int unsigned AccW = ADDR_BITS;
  localparam logic [MulW-1:0] MUL_ONE  = MulW'(1);
  localparam logic [MulW-1:0] MUL_FOUR = MulW'(4);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_SYM      = 12'b0000_0000_0010,
    S_CELL     = 12'b0000_0000_0100,
    S_CELL_B   = 12'b0000_0000_1000,
    S_FONT_A   = 12'b0000_0001_0000,
    S_FONT_B   = 12'b0000_0010_0000,
    S_REQ      = 12'b0000_0100_0000,
    S_PIX_BASE = 12'b0000_1000_0000,
    S_PIX      = 12'b0001_0000_0000,
    S_COL_END  = 12'b0010_0000_0000,
    S_DONE     = 12'b0100_0000_0000,
    S_ERR      = 12'b1000_0000_0000
  } state_e;

  gcce_cfg_t cfg;

  state_e                state_q, state_d;
  logic                  active_q, active_d;
  logic [ColBitsW-1:0]   bits_q, bits_d;
  logic [1:0]            rbi_q, rbi_d;
  logic [5:0]            col_q, col_d;
  logic [4:0]            row_q, row_d;

  logic [FontAddrW-1:0]  sym_base_q, sym_base_d;
  logic [AccW-1:0]       cell_base_q, cell_base_d;
  logic [ColorW-1:0]     fore_q, fore_d;
  logic [ColorW-1:0]     back_q, back_d;
  logic [7:0]            ch_q, ch_d;
  logic [PosW-1:0]       px_q, px_d;
  logic [PosW-1:0]       py_q, py_d;

  logic                  out_valid_q, out_valid_d;
  logic [KindW-1:0]      out_kind_q, out_kind_d;
  logic [PixAddrW-1:0]   out_addr_q, out_addr_d;
  logic [ColorW-1:0]     out_color_q, out_color_d;
  logic [FontAddrW-1:0]  out_font_q, out_font_d;
  logic                  out_last_q, out_last_d;

  logic                  mac_en;
  logic [MulW-1:0]       mac_a, mac_b;
  logic [AccW-1:0]       mac_c, acc;

  logic                  in_fire, out_free;
  logic [2:0]            rows, rbi_next;
  logic [5:0]            height, col_next;

  // Register block
  gcce_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Shared address unit
  gcce_mac #(
    .AccW (AccW)
  ) u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .acc_o (acc)
  );

  // Clamp the row byte count to 1..4 and the height to 32
  always_comb begin
    if (cfg.row_byte_count == 3'd0) begin
      rows = 3'd1;
    end else if (cfg.row_byte_count > MAX_ROW_BYTES) begin
      rows = MAX_ROW_BYTES;
    end else begin
      rows = cfg.row_byte_count;
    end
    height = (cfg.glyph_height > MAX_ROWS) ? MAX_ROWS : cfg.glyph_height;
  end

  assign item_i.ready = (state_q == S_IDLE);
  assign in_fire      = item_i.valid && (state_q == S_IDLE);
  assign out_free     = !out_valid_q || result_o.ready;
  assign rbi_next     = {1'b0, rbi_q} + 3'd1;
  assign col_next     = col_q + 6'd1;

  // Select the multiply-add operands for each step
  always_comb begin
    mac_en = 1'b0;
    mac_a  = '0;
    mac_b  = '0;
    mac_c  = '0;
    case (state_q)
      S_SYM: begin
        mac_en = 1'b1;
        mac_a  = MulW'(ch_q);
        mac_b  = MulW'(cfg.symbol_bytes);
      end
      S_CELL: begin
        mac_en = 1'b1;
        mac_a  = py_q;
        mac_b  = cfg.screen_width;
        mac_c  = AccW'(px_q);
      end
      S_FONT_A: begin
        mac_en = 1'b1;
        mac_a  = MulW'(rbi_q);
        mac_b  = MulW'(cfg.glyph_width);
        mac_c  = AccW'(sym_base_q);
      end
      S_FONT_B: begin
        mac_en = 1'b1;
        mac_a  = MulW'(col_q);
        mac_b  = MUL_ONE;
        mac_c  = acc;
      end
      S_PIX_BASE: begin
        mac_en = 1'b1;
        mac_a  = MulW'(col_q);
        mac_b  = MUL_FOUR;
        mac_c  = cell_base_q;
      end
      S_PIX: begin
        mac_en = out_free;
        mac_a  = cfg.screen_width;
        mac_b  = MUL_FOUR;
        mac_c  = acc;
      end
      default: begin
        mac_en = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    bits_d      = bits_q;
    rbi_d       = rbi_q;
    col_d       = col_q;
    row_d       = row_q;
    sym_base_d  = sym_base_q;
    cell_base_d = cell_base_q;
    fore_d      = fore_q;
    back_d      = back_q;
    ch_d        = ch_q;
    px_d        = px_q;
    py_d        = py_q;

    out_valid_d = out_valid_q && !result_o.ready;
    out_kind_d  = out_kind_q;
    out_addr_d  = out_addr_q;
    out_color_d = out_color_q;
    out_font_d  = out_font_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (item_i.opcode == OP_BEGIN) begin
            if (item_i.char_index > MAX_CHAR) begin
              active_d = 1'b0;
              state_d  = S_ERR;
            end else begin
              ch_d    = item_i.char_index[7:0];
              px_d    = item_i.pos_x;
              py_d    = item_i.pos_y;
              fore_d  = item_i.fore_color;
              back_d  = item_i.back_color;
              bits_d  = '0;
              rbi_d   = 2'd0;
              col_d   = 6'd0;
              state_d = S_SYM;
            end
          end else if (!active_q) begin
            state_d = S_ERR;
          end else begin
            // Merge the byte into the column word
            bits_d = bits_q | (ColBitsW'(item_i.glyph_byte) << {rbi_q, 3'b000});
            if (rbi_next < rows) begin
              rbi_d   = rbi_next[1:0];
              state_d = S_FONT_A;
            end else begin
              rbi_d   = 2'd0;
              state_d = S_PIX_BASE;
            end
          end
        end
      end
      S_SYM: begin
        state_d = S_CELL;
      end
      S_CELL: begin
        sym_base_d = acc[FontAddrW-1:0];
        state_d    = S_CELL_B;
      end
      S_CELL_B: begin
        cell_base_d = {acc[AccW-3:0], 2'b00};
        if (cfg.glyph_width == 6'd0) begin
          active_d = 1'b0;
          state_d  = S_DONE;
        end else begin
          active_d = 1'b1;
          state_d  = S_FONT_A;
        end
      end
      S_FONT_A: begin
        state_d = S_FONT_B;
      end
      S_FONT_B: begin
        state_d = S_REQ;
      end
      S_REQ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_REQ;
          out_addr_d  = '0;
          out_color_d = '0;
          out_font_d  = acc[FontAddrW-1:0];
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_PIX_BASE: begin
        row_d   = 5'd0;
        state_d = (height == 6'd0) ? S_COL_END : S_PIX;
      end
      S_PIX: begin
        // Emit one pixel and step one line down
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_PIX;
          out_addr_d  = PixAddrW'(acc);
          out_color_d = bits_q[0] ? fore_q : back_q;
          out_font_d  = '0;
          out_last_d  = 1'b0;
          bits_d      = bits_q >> 1;
          row_d       = row_q + 5'd1;
          if ((6'(row_q) + 6'd1) == height) begin
            state_d = S_COL_END;
          end
        end
      end
      S_COL_END: begin
        bits_d = '0;
        if ((col_next == 6'd0) || (col_next >= cfg.glyph_width)) begin
          active_d = 1'b0;
          col_d    = 6'd0;
          state_d  = S_DONE;
        end else begin
          col_d   = col_next;
          state_d = S_FONT_A;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_DONE;
          out_addr_d  = '0;
          out_color_d = '0;
          out_font_d  = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_ERR;
          out_addr_d  = '0;
          out_color_d = '0;
          out_font_d  = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      bits_q      <= '0;
      rbi_q       <= 2'd0;
      col_q       <= 6'd0;
      row_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      bits_q      <= bits_d;
      rbi_q       <= rbi_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sym_base_q  <= sym_base_d;
    cell_base_q <= cell_base_d;
    fore_q      <= fore_d;
    back_q      <= back_d;
    ch_q        <= ch_d;
    px_q        <= px_d;
    py_q        <= py_d;
    out_kind_q  <= out_kind_d;
    out_addr_q  <= out_addr_d;
    out_color_q <= out_color_d;
    out_font_q  <= out_font_d;
    out_last_q  <= out_last_d;
  end

  // Drive the result channel
  assign result_o.valid       = out_valid_q;
  assign result_o.result_kind = out_kind_q;
  assign result_o.pixel_addr  = out_addr_q;
  assign result_o.pixel_color = out_color_q;
  assign result_o.font_addr   = out_font_q;
  assign result_o.last        = out_last_q;

  // Checks
  `GCCE_ASSERT(a_pix_not_last, clk_i, rst_ni,
    (result_o.valid && (result_o.result_kind == KIND_PIX) |-> !result_o.last),
    "pixel write marked last")
  `GCCE_ASSERT_NEXT(a_idle_byte_err, clk_i, rst_ni,
    in_fire && (item_i.opcode == OP_BYTE) && !active_q, state_q == S_ERR,
    "byte while idle not rejected")
  `GCCE_ASSERT_NEXT(a_pix_load, clk_i, rst_ni, (state_q == S_PIX) && out_free,
    result_o.valid && (result_o.result_kind == KIND_PIX), "pixel step did not load a write")
  `GCCE_ASSERT_NEXT(a_req_load, clk_i, rst_ni, (state_q == S_REQ) && out_free,
    result_o.valid && result_o.last && (result_o.result_kind == KIND_REQ), "request not loaded")

endmodule

// File: design/gcce_cfg_regs.sv
`timescale 1ns / 1ps

module gcce_cfg_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gcce_cfg_if.sink              cfg_i,
  output gcce_pkg::gcce_cfg_t   cfg_o
);
  import gcce_pkg::*;

  gcce_cfg_t regs_q, regs_d;

  // Always take a write
  assign cfg_i.ready = 1'b1;

  // Update the addressed register; unknown indexes are dropped
  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SCREEN_WIDTH:   regs_d.screen_width   = cfg_i.data[11:0];
        REG_GLYPH_WIDTH:    regs_d.glyph_width    = cfg_i.data[5:0];
        REG_GLYPH_HEIGHT:   regs_d.glyph_height   = cfg_i.data[5:0];
        REG_ROW_BYTE_COUNT: regs_d.row_byte_count = cfg_i.data[2:0];
        REG_SYMBOL_BYTES:   regs_d.symbol_bytes   = cfg_i.data[7:0];
        default:            regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CFG_RESET;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign cfg_o = regs_q;

endmodule

// File: design/gcce_mac.sv
`timescale 1ns / 1ps

module gcce_mac #(
  parameter int unsigned AccW = 24
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [gcce_pkg::MulW-1:0]   a_i,
  input  logic [gcce_pkg::MulW-1:0]   b_i,
  input  logic [AccW-1:0]             c_i,
  output logic [AccW-1:0]             acc_o
);
  import gcce_pkg::*;

  logic [2*MulW-1:0] prod;
  logic [AccW-1:0]   acc_q, acc_d;

  // Multiply, add and wrap at the accumulator width
  assign prod  = a_i * b_i;
  assign acc_d = AccW'(prod) + c_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
